FILE: rtl/c02dec_pkg.sv
// ----------------------------------------------------------------------------
// c02dec_pkg
// Types, codes and the opcode table of the CMOS 6502 instruction decoder.
// ----------------------------------------------------------------------------
package c02dec_pkg;

  localparam int unsigned MnemW = 7;

  typedef enum logic [3:0] {
    AM_IMP = 4'd0, AM_ACC = 4'd1, AM_IMM = 4'd2, AM_ZP = 4'd3,
    AM_ZPX = 4'd4, AM_ZPY = 4'd5, AM_IZX = 4'd6, AM_IZY = 4'd7,
    AM_IZP = 4'd8, AM_REL = 4'd9, AM_ABS = 4'd10, AM_ABX = 4'd11,
    AM_ABY = 4'd12, AM_IND = 4'd13, AM_IAX = 4'd14, AM_ZPR = 4'd15
  } addr_mode_e;

  typedef enum logic [2:0] {
    FL_NO = 3'd0, FL_BR = 3'd1, FL_JP = 3'd2, FL_CL = 3'd3,
    FL_RT = 3'd4, FL_BK = 3'd5, FL_ST = 3'd6
  } flow_e;

  typedef enum logic [MnemW-1:0] {
    I_BRK, I_ORA, I_NOP, I_TSB, I_ASL, I_RMB0, I_PHP, I_BBR0,
    I_BPL, I_TRB, I_RMB1, I_CLC, I_INC, I_BBR1,
    I_JSR, I_AND, I_BIT, I_ROL, I_RMB2, I_PLP, I_BBR2,
    I_BMI, I_RMB3, I_SEC, I_DEC, I_BBR3,
    I_RTI, I_EOR, I_LSR, I_RMB4, I_PHA, I_JMP, I_BBR4,
    I_BVC, I_RMB5, I_CLI, I_PHY, I_BBR5,
    I_RTS, I_ADC, I_STZ, I_ROR, I_RMB6, I_PLA, I_BBR6,
    I_BVS, I_RMB7, I_SEI, I_PLY, I_BBR7,
    I_BRA, I_STA, I_STY, I_STX, I_SMB0, I_DEY, I_TXA, I_BBS0,
    I_BCC, I_SMB1, I_TYA, I_TXS, I_BBS1,
    I_LDY, I_LDA, I_LDX, I_SMB2, I_TAY, I_TAX, I_BBS2,
    I_BCS, I_SMB3, I_CLV, I_TSX, I_BBS3,
    I_CPY, I_CMP, I_SMB4, I_INY, I_DEX, I_WAI, I_BBS4,
    I_BNE, I_SMB5, I_CLD, I_PHX, I_STP, I_BBS5,
    I_CPX, I_SBC, I_SMB6, I_INX, I_BBS6,
    I_BEQ, I_SMB7, I_SED, I_PLX, I_BBS7
  } mnem_e;

  typedef struct packed {
    mnem_e      mnem;
    addr_mode_e mode;
    flow_e      flow;
  } op_entry_t;

  typedef struct packed {
    logic [7:0]  opcode_byte;
    logic [7:0]  first_follow_byte;
    logic [7:0]  second_follow_byte;
    logic [15:0] instr_address;
  } dec_in_t;

  typedef struct packed {
    logic [6:0]  mnemonic_id;
    logic [3:0]  addr_mode;
    logic [2:0]  flow_class;
    logic [1:0]  instr_length;
    logic [2:0]  bit_index;
    logic [15:0] operand_value;
    logic [15:0] branch_target;
  } dec_out_t;

  function automatic op_entry_t e(mnem_e m, addr_mode_e a, flow_e f);
    op_entry_t r;
    r.mnem = m;
    r.mode = a;
    r.flow = f;
    return r;
  endfunction

  function automatic op_entry_t op_lookup(logic [7:0] op);
    op_entry_t r;
    r = e(I_NOP, AM_IMP, FL_NO);
    unique case (op)
      8'h00: r = e(I_BRK, AM_IMP, FL_BK);  8'h01: r = e(I_ORA, AM_IZX, FL_NO);
      8'h02: r = e(I_NOP, AM_IMM, FL_NO);  8'h04: r = e(I_TSB, AM_ZP, FL_NO);
      8'h05: r = e(I_ORA, AM_ZP, FL_NO);   8'h06: r = e(I_ASL, AM_ZP, FL_NO);
      8'h07: r = e(I_RMB0, AM_ZP, FL_NO);  8'h08: r = e(I_PHP, AM_IMP, FL_NO);
      8'h09: r = e(I_ORA, AM_IMM, FL_NO);  8'h0A: r = e(I_ASL, AM_ACC, FL_NO);
      8'h0C: r = e(I_TSB, AM_ABS, FL_NO);  8'h0D: r = e(I_ORA, AM_ABS, FL_NO);
      8'h0E: r = e(I_ASL, AM_ABS, FL_NO);  8'h0F: r = e(I_BBR0, AM_ZPR, FL_BR);
      8'h10: r = e(I_BPL, AM_REL, FL_BR);  8'h11: r = e(I_ORA, AM_IZY, FL_NO);
      8'h12: r = e(I_ORA, AM_IZP, FL_NO);  8'h14: r = e(I_TRB, AM_ZP, FL_NO);
      8'h15: r = e(I_ORA, AM_ZPX, FL_NO);  8'h16: r = e(I_ASL, AM_ZPX, FL_NO);
      8'h17: r = e(I_RMB1, AM_ZP, FL_NO);  8'h18: r = e(I_CLC, AM_IMP, FL_NO);
      8'h19: r = e(I_ORA, AM_ABY, FL_NO);  8'h1A: r = e(I_INC, AM_ACC, FL_NO);
      8'h1C: r = e(I_TRB, AM_ABS, FL_NO);  8'h1D: r = e(I_ORA, AM_ABX, FL_NO);
      8'h1E: r = e(I_ASL, AM_ABX, FL_NO);  8'h1F: r = e(I_BBR1, AM_ZPR, FL_BR);
      8'h20: r = e(I_JSR, AM_ABS, FL_CL);  8'h21: r = e(I_AND, AM_IZX, FL_NO);
      8'h22: r = e(I_NOP, AM_IMM, FL_NO);  8'h24: r = e(I_BIT, AM_ZP, FL_NO);
      8'h25: r = e(I_AND, AM_ZP, FL_NO);   8'h26: r = e(I_ROL, AM_ZP, FL_NO);
      8'h27: r = e(I_RMB2, AM_ZP, FL_NO);  8'h28: r = e(I_PLP, AM_IMP, FL_NO);
      8'h29: r = e(I_AND, AM_IMM, FL_NO);  8'h2A: r = e(I_ROL, AM_ACC, FL_NO);
      8'h2C: r = e(I_BIT, AM_ABS, FL_NO);  8'h2D: r = e(I_AND, AM_ABS, FL_NO);
      8'h2E: r = e(I_ROL, AM_ABS, FL_NO);  8'h2F: r = e(I_BBR2, AM_ZPR, FL_BR);
      8'h30: r = e(I_BMI, AM_REL, FL_BR);  8'h31: r = e(I_AND, AM_IZY, FL_NO);
      8'h32: r = e(I_AND, AM_IZP, FL_NO);  8'h34: r = e(I_BIT, AM_ZPX, FL_NO);
      8'h35: r = e(I_AND, AM_ZPX, FL_NO);  8'h36: r = e(I_ROL, AM_ZPX, FL_NO);
      8'h37: r = e(I_RMB3, AM_ZP, FL_NO);  8'h38: r = e(I_SEC, AM_IMP, FL_NO);
      8'h39: r = e(I_AND, AM_ABY, FL_NO);  8'h3A: r = e(I_DEC, AM_ACC, FL_NO);
      8'h3C: r = e(I_BIT, AM_ABX, FL_NO);  8'h3D: r = e(I_AND, AM_ABX, FL_NO);
      8'h3E: r = e(I_ROL, AM_ABX, FL_NO);  8'h3F: r = e(I_BBR3, AM_ZPR, FL_BR);
      8'h40: r = e(I_RTI, AM_IMP, FL_RT);  8'h41: r = e(I_EOR, AM_IZX, FL_NO);
      8'h42: r = e(I_NOP, AM_IMM, FL_NO);  8'h44: r = e(I_NOP, AM_ZP, FL_NO);
      8'h45: r = e(I_EOR, AM_ZP, FL_NO);   8'h46: r = e(I_LSR, AM_ZP, FL_NO);
      8'h47: r = e(I_RMB4, AM_ZP, FL_NO);  8'h48: r = e(I_PHA, AM_IMP, FL_NO);
      8'h49: r = e(I_EOR, AM_IMM, FL_NO);  8'h4A: r = e(I_LSR, AM_ACC, FL_NO);
      8'h4C: r = e(I_JMP, AM_ABS, FL_JP);  8'h4D: r = e(I_EOR, AM_ABS, FL_NO);
      8'h4E: r = e(I_LSR, AM_ABS, FL_NO);  8'h4F: r = e(I_BBR4, AM_ZPR, FL_BR);
      8'h50: r = e(I_BVC, AM_REL, FL_BR);  8'h51: r = e(I_EOR, AM_IZY, FL_NO);
      8'h52: r = e(I_EOR, AM_IZP, FL_NO);  8'h54: r = e(I_NOP, AM_ZPX, FL_NO);
      8'h55: r = e(I_EOR, AM_ZPX, FL_NO);  8'h56: r = e(I_LSR, AM_ZPX, FL_NO);
      8'h57: r = e(I_RMB5, AM_ZP, FL_NO);  8'h58: r = e(I_CLI, AM_IMP, FL_NO);
      8'h59: r = e(I_EOR, AM_ABY, FL_NO);  8'h5A: r = e(I_PHY, AM_IMP, FL_NO);
      8'h5C: r = e(I_NOP, AM_ABS, FL_NO);  8'h5D: r = e(I_EOR, AM_ABX, FL_NO);
      8'h5E: r = e(I_LSR, AM_ABX, FL_NO);  8'h5F: r = e(I_BBR5, AM_ZPR, FL_BR);
      8'h60: r = e(I_RTS, AM_IMP, FL_RT);  8'h61: r = e(I_ADC, AM_IZX, FL_NO);
      8'h62: r = e(I_NOP, AM_IMM, FL_NO);  8'h64: r = e(I_STZ, AM_ZP, FL_NO);
      8'h65: r = e(I_ADC, AM_ZP, FL_NO);   8'h66: r = e(I_ROR, AM_ZP, FL_NO);
      8'h67: r = e(I_RMB6, AM_ZP, FL_NO);  8'h68: r = e(I_PLA, AM_IMP, FL_NO);
      8'h69: r = e(I_ADC, AM_IMM, FL_NO);  8'h6A: r = e(I_ROR, AM_ACC, FL_NO);
      8'h6C: r = e(I_JMP, AM_IND, FL_JP);  8'h6D: r = e(I_ADC, AM_ABS, FL_NO);
      8'h6E: r = e(I_ROR, AM_ABS, FL_NO);  8'h6F: r = e(I_BBR6, AM_ZPR, FL_BR);
      8'h70: r = e(I_BVS, AM_REL, FL_BR);  8'h71: r = e(I_ADC, AM_IZY, FL_NO);
      8'h72: r = e(I_ADC, AM_IZP, FL_NO);  8'h74: r = e(I_STZ, AM_ZPX, FL_NO);
      8'h75: r = e(I_ADC, AM_ZPX, FL_NO);  8'h76: r = e(I_ROR, AM_ZPX, FL_NO);
      8'h77: r = e(I_RMB7, AM_ZP, FL_NO);  8'h78: r = e(I_SEI, AM_IMP, FL_NO);
      8'h79: r = e(I_ADC, AM_ABY, FL_NO);  8'h7A: r = e(I_PLY, AM_IMP, FL_NO);
      8'h7C: r = e(I_JMP, AM_IAX, FL_JP);  8'h7D: r = e(I_ADC, AM_ABX, FL_NO);
      8'h7E: r = e(I_ROR, AM_ABX, FL_NO);  8'h7F: r = e(I_BBR7, AM_ZPR, FL_BR);
      8'h80: r = e(I_BRA, AM_REL, FL_JP);  8'h81: r = e(I_STA, AM_IZX, FL_NO);
      8'h82: r = e(I_NOP, AM_IMM, FL_NO);  8'h84: r = e(I_STY, AM_ZP, FL_NO);
      8'h85: r = e(I_STA, AM_ZP, FL_NO);   8'h86: r = e(I_STX, AM_ZP, FL_NO);
      8'h87: r = e(I_SMB0, AM_ZP, FL_NO);  8'h88: r = e(I_DEY, AM_IMP, FL_NO);
      8'h89: r = e(I_BIT, AM_IMM, FL_NO);  8'h8A: r = e(I_TXA, AM_IMP, FL_NO);
      8'h8C: r = e(I_STY, AM_ABS, FL_NO);  8'h8D: r = e(I_STA, AM_ABS, FL_NO);
      8'h8E: r = e(I_STX, AM_ABS, FL_NO);  8'h8F: r = e(I_BBS0, AM_ZPR, FL_BR);
      8'h90: r = e(I_BCC, AM_REL, FL_BR);  8'h91: r = e(I_STA, AM_IZY, FL_NO);
      8'h92: r = e(I_STA, AM_IZP, FL_NO);  8'h94: r = e(I_STY, AM_ZPX, FL_NO);
      8'h95: r = e(I_STA, AM_ZPX, FL_NO);  8'h96: r = e(I_STX, AM_ZPY, FL_NO);
      8'h97: r = e(I_SMB1, AM_ZP, FL_NO);  8'h98: r = e(I_TYA, AM_IMP, FL_NO);
      8'h99: r = e(I_STA, AM_ABY, FL_NO);  8'h9A: r = e(I_TXS, AM_IMP, FL_NO);
      8'h9C: r = e(I_STZ, AM_ABS, FL_NO);  8'h9D: r = e(I_STA, AM_ABX, FL_NO);
      8'h9E: r = e(I_STZ, AM_ABX, FL_NO);  8'h9F: r = e(I_BBS1, AM_ZPR, FL_BR);
      8'hA0: r = e(I_LDY, AM_IMM, FL_NO);  8'hA1: r = e(I_LDA, AM_IZX, FL_NO);
      8'hA2: r = e(I_LDX, AM_IMM, FL_NO);  8'hA4: r = e(I_LDY, AM_ZP, FL_NO);
      8'hA5: r = e(I_LDA, AM_ZP, FL_NO);   8'hA6: r = e(I_LDX, AM_ZP, FL_NO);
      8'hA7: r = e(I_SMB2, AM_ZP, FL_NO);  8'hA8: r = e(I_TAY, AM_IMP, FL_NO);
      8'hA9: r = e(I_LDA, AM_IMM, FL_NO);  8'hAA: r = e(I_TAX, AM_IMP, FL_NO);
      8'hAC: r = e(I_LDY, AM_ABS, FL_NO);  8'hAD: r = e(I_LDA, AM_ABS, FL_NO);
      8'hAE: r = e(I_LDX, AM_ABS, FL_NO);  8'hAF: r = e(I_BBS2, AM_ZPR, FL_BR);
      8'hB0: r = e(I_BCS, AM_REL, FL_BR);  8'hB1: r = e(I_LDA, AM_IZY, FL_NO);
      8'hB2: r = e(I_LDA, AM_IZP, FL_NO);  8'hB4: r = e(I_LDY, AM_ZPX, FL_NO);
      8'hB5: r = e(I_LDA, AM_ZPX, FL_NO);  8'hB6: r = e(I_LDX, AM_ZPY, FL_NO);
      8'hB7: r = e(I_SMB3, AM_ZP, FL_NO);  8'hB8: r = e(I_CLV, AM_IMP, FL_NO);
      8'hB9: r = e(I_LDA, AM_ABY, FL_NO);  8'hBA: r = e(I_TSX, AM_IMP, FL_NO);
      8'hBC: r = e(I_LDY, AM_ABX, FL_NO);  8'hBD: r = e(I_LDA, AM_ABX, FL_NO);
      8'hBE: r = e(I_LDX, AM_ABY, FL_NO);  8'hBF: r = e(I_BBS3, AM_ZPR, FL_BR);
      8'hC0: r = e(I_CPY, AM_IMM, FL_NO);  8'hC1: r = e(I_CMP, AM_IZX, FL_NO);
      8'hC2: r = e(I_NOP, AM_IMM, FL_NO);  8'hC4: r = e(I_CPY, AM_ZP, FL_NO);
      8'hC5: r = e(I_CMP, AM_ZP, FL_NO);   8'hC6: r = e(I_DEC, AM_ZP, FL_NO);
      8'hC7: r = e(I_SMB4, AM_ZP, FL_NO);  8'hC8: r = e(I_INY, AM_IMP, FL_NO);
      8'hC9: r = e(I_CMP, AM_IMM, FL_NO);  8'hCA: r = e(I_DEX, AM_IMP, FL_NO);
      8'hCB: r = e(I_WAI, AM_IMP, FL_ST);  8'hCC: r = e(I_CPY, AM_ABS, FL_NO);
      8'hCD: r = e(I_CMP, AM_ABS, FL_NO);  8'hCE: r = e(I_DEC, AM_ABS, FL_NO);
      8'hCF: r = e(I_BBS4, AM_ZPR, FL_BR);
      8'hD0: r = e(I_BNE, AM_REL, FL_BR);  8'hD1: r = e(I_CMP, AM_IZY, FL_NO);
      8'hD2: r = e(I_CMP, AM_IZP, FL_NO);  8'hD4: r = e(I_NOP, AM_ZPX, FL_NO);
      8'hD5: r = e(I_CMP, AM_ZPX, FL_NO);  8'hD6: r = e(I_DEC, AM_ZPX, FL_NO);
      8'hD7: r = e(I_SMB5, AM_ZP, FL_NO);  8'hD8: r = e(I_CLD, AM_IMP, FL_NO);
      8'hD9: r = e(I_CMP, AM_ABY, FL_NO);  8'hDA: r = e(I_PHX, AM_IMP, FL_NO);
      8'hDB: r = e(I_STP, AM_IMP, FL_ST);  8'hDC: r = e(I_NOP, AM_ABS, FL_NO);
      8'hDD: r = e(I_CMP, AM_ABX, FL_NO);  8'hDE: r = e(I_DEC, AM_ABX, FL_NO);
      8'hDF: r = e(I_BBS5, AM_ZPR, FL_BR);
      8'hE0: r = e(I_CPX, AM_IMM, FL_NO);  8'hE1: r = e(I_SBC, AM_IZX, FL_NO);
      8'hE2: r = e(I_NOP, AM_IMM, FL_NO);  8'hE4: r = e(I_CPX, AM_ZP, FL_NO);
      8'hE5: r = e(I_SBC, AM_ZP, FL_NO);   8'hE6: r = e(I_INC, AM_ZP, FL_NO);
      8'hE7: r = e(I_SMB6, AM_ZP, FL_NO);  8'hE8: r = e(I_INX, AM_IMP, FL_NO);
      8'hE9: r = e(I_SBC, AM_IMM, FL_NO);  8'hEC: r = e(I_CPX, AM_ABS, FL_NO);
      8'hED: r = e(I_SBC, AM_ABS, FL_NO);  8'hEE: r = e(I_INC, AM_ABS, FL_NO);
      8'hEF: r = e(I_BBS6, AM_ZPR, FL_BR);
      8'hF0: r = e(I_BEQ, AM_REL, FL_BR);  8'hF1: r = e(I_SBC, AM_IZY, FL_NO);
      8'hF2: r = e(I_SBC, AM_IZP, FL_NO);  8'hF4: r = e(I_NOP, AM_ZPX, FL_NO);
      8'hF5: r = e(I_SBC, AM_ZPX, FL_NO);  8'hF6: r = e(I_INC, AM_ZPX, FL_NO);
      8'hF7: r = e(I_SMB7, AM_ZP, FL_NO);  8'hF8: r = e(I_SED, AM_IMP, FL_NO);
      8'hF9: r = e(I_SBC, AM_ABY, FL_NO);  8'hFA: r = e(I_PLX, AM_IMP, FL_NO);
      8'hFC: r = e(I_NOP, AM_ABS, FL_NO);  8'hFD: r = e(I_SBC, AM_ABX, FL_NO);
      8'hFE: r = e(I_INC, AM_ABX, FL_NO);  8'hFF: r = e(I_BBS7, AM_ZPR, FL_BR);
      default: r = e(I_NOP, AM_IMP, FL_NO);
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/c02dec_if.sv
// ----------------------------------------------------------------------------
// c02dec_if
// Valid/ready channel carrying one decoder payload.
// ----------------------------------------------------------------------------
interface c02dec_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/c02dec_logic.sv
// ----------------------------------------------------------------------------
// c02dec_logic
// Table lookup, operand extraction and target add for one instruction.
// ----------------------------------------------------------------------------
module c02dec_logic (
  input  c02dec_pkg::dec_in_t  item_i,
  output c02dec_pkg::dec_out_t res_o
);
  import c02dec_pkg::*;

  op_entry_t   ent;
  logic [15:0] word;
  logic [15:0] disp;
  logic [15:0] base;

  assign ent  = op_lookup(item_i.opcode_byte);
  assign word = {item_i.second_follow_byte, item_i.first_follow_byte};

  always_comb begin
    res_o = '0;
    res_o.mnemonic_id = ent.mnem;
    res_o.addr_mode   = ent.mode;
    res_o.flow_class  = ent.flow;
    if (ent.mode == AM_IMP || ent.mode == AM_ACC) begin
      res_o.instr_length = 2'd1;
    end else if (ent.mode <= AM_REL) begin
      res_o.instr_length = 2'd2;
    end else begin
      res_o.instr_length = 2'd3;
    end
    if (item_i.opcode_byte[2:0] == 3'b111) begin
      res_o.bit_index = item_i.opcode_byte[6:4];
    end
    // zprel displaces by the second byte from pc+3, rel by the first from pc+2
    if (ent.mode == AM_ZPR) begin
      disp = {{8{item_i.second_follow_byte[7]}}, item_i.second_follow_byte};
      base = 16'd3;
    end else begin
      disp = {{8{item_i.first_follow_byte[7]}}, item_i.first_follow_byte};
      base = 16'd2;
    end
    if (ent.mode == AM_ZPR || ent.mode == AM_REL) begin
      res_o.operand_value = {8'h00, item_i.first_follow_byte};
      res_o.branch_target = item_i.instr_address + base + disp;
    end else if (ent.mode >= AM_ABS) begin
      res_o.operand_value = word;
      if (ent.mode == AM_ABS && (ent.flow == FL_JP || ent.flow == FL_CL)) begin
        res_o.branch_target = word;
      end
    end else if (ent.mode >= AM_IMM) begin
      res_o.operand_value = {8'h00, item_i.first_follow_byte};
    end
  end
endmodule

FILE: rtl/cmos6502_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// cmos6502_instruction_decoder_top
// CMOS 6502 instruction decoder with registered input and result stages.
// ----------------------------------------------------------------------------
// One request is accepted per cycle whenever the input stage is empty or can advance.
// It is captured in an input register, which feeds the table lookup and the 16-bit
// target add, and that output is held in a result register. Both stages
// advance whenever the result stage is empty or being taken, so throughput
// is one per cycle.
module cmos6502_instruction_decoder_top (
  input logic  clk_i,
  input logic  rst_ni,
  c02dec_if.sink   in_if,
  c02dec_if.source out_if
);
  import c02dec_pkg::*;

  logic     in_vld_q, out_vld_q;
  dec_in_t  in_q;
  dec_out_t res_d, out_q;
  logic     adv_out, adv_in;

  assign adv_out     = !out_vld_q || out_if.ready;
  assign adv_in      = !in_vld_q || adv_out;
  assign in_if.ready = adv_in;

  c02dec_logic u_logic (
    .item_i (in_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) in_vld_q <= in_if.valid;
      if (adv_out) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_if.valid) in_q <= in_if.data;
    if (adv_out && in_vld_q) out_q <= res_d;
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

  // a held result is not overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_if.ready |=> $stable(out_q))
    else $error("result changed under stall");

  // length follows the mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.addr_mode <= AM_ACC) == (out_q.instr_length == 2'd1)))
    else $error("length mismatch");

  // an accepted request reaches the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> in_vld_q)
    else $error("request lost");
endmodule
